// ===== rtl/lz4bd_pkg.sv =====
package lz4bd_pkg;

  localparam int unsigned SizeBits   = 24;
  localparam int unsigned HistDepth  = 65536;
  localparam int unsigned HistAw     = $clog2(HistDepth);
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoAw     = $clog2(FifoDepth);
  localparam int unsigned MaxResults = 2;
  localparam int unsigned MinMatch   = 4;

  localparam logic [7:0] ExtByte   = 8'hFF;
  localparam logic [3:0] ExtNibble = 4'hF;

  typedef logic [SizeBits-1:0] size_t;
  typedef logic [HistAw-1:0]   haddr_t;

  typedef enum logic [1:0] {
    KIND_LITERAL,
    KIND_MATCH,
    KIND_DONE,
    KIND_ERROR
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_TRUNCATED,
    ERR_LIT_OVERRUN,
    ERR_BAD_OFFSET,
    ERR_MATCH_OVERRUN,
    ERR_SIZE_MISMATCH,
    ERR_BUSY
  } err_e;

  // What the parser hands to the resolve stage for one accepted request.
  typedef struct packed {
    logic       byte_v;
    logic       byte_match;
    logic [7:0] lit_byte;
    logic       busy;
    logic       fin_v;
    kind_e      fin_kind;
    err_e       fin_err;
    haddr_t     rd_addr;
    haddr_t     wr_addr;
  } issue_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    err_e       error_code;
    logic       busy_res;
    logic       run_last;
  } result_t;

endpackage

// ===== rtl/lz4bd_if.sv =====
interface lz4bd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output op, output data_byte, output is_last, input ready);
  modport sink (input valid, input op, input data_byte, input is_last, output ready);
endinterface

interface lz4bd_out_if import lz4bd_pkg::*; ;
  logic       valid;
  logic       ready;
  kind_e      kind;
  logic [7:0] out_byte;
  err_e       error_code;
  logic       busy_res;
  logic       run_last;

  modport source (
    output valid, output kind, output out_byte, output error_code, output busy_res,
    output run_last, input ready
  );
  modport sink (
    input valid, input kind, input out_byte, input error_code, input busy_res,
    input run_last, output ready
  );
endinterface

// ===== rtl/lz4bd_history.sv =====
module lz4bd_history import lz4bd_pkg::*; (
  input  logic       clk_i,
  input  logic       wr_en_i,
  input  haddr_t     wr_addr_i,
  input  logic [7:0] wr_data_i,
  input  logic       rd_en_i,
  input  haddr_t     rd_addr_i,
  output logic [7:0] rd_data_o
);

  logic [7:0] mem_q [HistDepth];
  logic [7:0] rd_data_q;

  // Read-first: a read of the address being written returns the old byte.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/lz4bd_parser.sv =====
module lz4bd_parser import lz4bd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic       op_i,
  input  logic [7:0] data_byte_i,
  input  logic       is_last_i,
  input  size_t      expected_i,
  output issue_t     issue_o,
  output logic       rd_en_o
);

  localparam int unsigned AccW = SizeBits + 1;
  localparam int unsigned SumW = AccW + 1;
  localparam logic [AccW-1:0] SatLimit = {1'b1, {SizeBits{1'b0}}};

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_LITLEN,
    PH_LITERALS,
    PH_OFF_LO,
    PH_OFF_HI,
    PH_MATCHLEN,
    PH_COPY
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [3:0]      match_nibble_q, match_nibble_d;
  logic [AccW-1:0] length_accum_q, length_accum_d;
  size_t           literals_left_q, literals_left_d;
  haddr_t          match_distance_q, match_distance_d;
  size_t           match_left_q, match_left_d;
  size_t           produced_q, produced_d;
  logic            input_ended_q, input_ended_d;

  logic            lit_req, match_req, emit, ended_eff, end_req, fail;
  logic [AccW-1:0] lit_len, match_len, acc_sum;
  size_t           emit_len;
  haddr_t          dist_full;
  err_e            fail_code;

  function automatic logic [AccW-1:0] sat_add(input logic [AccW-1:0] a, input logic [7:0] b);
    logic [SumW-1:0] s;
    s = SumW'(a) + SumW'(b);
    return (s > SumW'(SatLimit)) ? SatLimit : s[AccW-1:0];
  endfunction

  // A length overruns when it does not fit in the space still expected.
  function automatic logic overrun(input logic [AccW-1:0] len, input size_t prod,
                                   input size_t expect_sz);
    logic [SumW-1:0] s;
    s = SumW'(len) + SumW'(prod);
    return s > SumW'(expect_sz);
  endfunction

  always_comb begin
    phase_d          = phase_q;
    match_nibble_d   = match_nibble_q;
    length_accum_d   = length_accum_q;
    literals_left_d  = literals_left_q;
    match_distance_d = match_distance_q;
    match_left_d     = match_left_q;
    produced_d       = produced_q;
    input_ended_d    = input_ended_q;
    issue_o          = '0;
    lit_req          = 1'b0;
    lit_len          = '0;
    match_req        = 1'b0;
    match_len        = '0;
    emit             = 1'b0;
    emit_len         = match_left_q;
    ended_eff        = input_ended_q;
    end_req          = 1'b0;
    fail             = 1'b0;
    fail_code        = ERR_NONE;
    acc_sum          = sat_add(length_accum_q, data_byte_i);
    dist_full        = {data_byte_i, match_distance_q[7:0]};

    if (fire_i) begin
      if (op_i) begin
        if (phase_q == PH_COPY && match_left_q != '0) begin
          emit = 1'b1;
        end
      end else begin
        unique case (phase_q)
          PH_TOKEN: begin
            match_nibble_d = data_byte_i[3:0];
            if (data_byte_i[7:4] == ExtNibble) begin
              length_accum_d = AccW'(ExtNibble);
              if (is_last_i) begin
                fail      = 1'b1;
                fail_code = ERR_TRUNCATED;
              end else begin
                phase_d = PH_LITLEN;
              end
            end else begin
              lit_req = 1'b1;
              lit_len = AccW'(data_byte_i[7:4]);
            end
          end
          PH_LITLEN: begin
            length_accum_d = acc_sum;
            if (data_byte_i == ExtByte) begin
              if (is_last_i) begin
                fail      = 1'b1;
                fail_code = ERR_TRUNCATED;
              end
            end else begin
              lit_req = 1'b1;
              lit_len = acc_sum;
            end
          end
          PH_LITERALS: begin
            issue_o.byte_v   = 1'b1;
            issue_o.lit_byte = data_byte_i;
            issue_o.wr_addr  = produced_q[HistAw-1:0];
            produced_d       = produced_q + 1'b1;
            literals_left_d  = literals_left_q - 1'b1;
            if (literals_left_d == '0) begin
              if (is_last_i) begin
                end_req = 1'b1;
              end else begin
                phase_d = PH_OFF_LO;
              end
            end else if (is_last_i) begin
              fail      = 1'b1;
              fail_code = ERR_TRUNCATED;
            end
          end
          PH_OFF_LO: begin
            match_distance_d = HistAw'(data_byte_i);
            if (is_last_i) begin
              fail      = 1'b1;
              fail_code = ERR_TRUNCATED;
            end else begin
              phase_d = PH_OFF_HI;
            end
          end
          PH_OFF_HI: begin
            match_distance_d = dist_full;
            if (dist_full == '0 || SizeBits'(dist_full) > produced_q) begin
              fail      = 1'b1;
              fail_code = ERR_BAD_OFFSET;
            end else if (match_nibble_q == ExtNibble) begin
              length_accum_d = AccW'(ExtNibble);
              if (is_last_i) begin
                fail      = 1'b1;
                fail_code = ERR_TRUNCATED;
              end else begin
                phase_d = PH_MATCHLEN;
              end
            end else begin
              match_req = 1'b1;
              match_len = AccW'(match_nibble_q) + AccW'(MinMatch);
            end
          end
          PH_MATCHLEN: begin
            length_accum_d = acc_sum;
            if (data_byte_i == ExtByte) begin
              if (is_last_i) begin
                fail      = 1'b1;
                fail_code = ERR_TRUNCATED;
              end
            end else begin
              match_req = 1'b1;
              match_len = sat_add(acc_sum, 8'(MinMatch));
            end
          end
          default: begin
            fail      = 1'b1;
            fail_code = ERR_BUSY;
          end
        endcase

        if (lit_req) begin
          if (lit_len == '0) begin
            if (is_last_i) begin
              end_req = 1'b1;
            end else begin
              phase_d = PH_OFF_LO;
            end
          end else if (is_last_i) begin
            fail      = 1'b1;
            fail_code = ERR_TRUNCATED;
          end else if (overrun(lit_len, produced_q, expected_i)) begin
            fail      = 1'b1;
            fail_code = ERR_LIT_OVERRUN;
          end else begin
            literals_left_d = lit_len[SizeBits-1:0];
            phase_d         = PH_LITERALS;
          end
        end

        if (match_req) begin
          if (overrun(match_len, produced_q, expected_i)) begin
            fail      = 1'b1;
            fail_code = ERR_MATCH_OVERRUN;
          end else begin
            emit      = 1'b1;
            emit_len  = match_len[SizeBits-1:0];
            ended_eff = is_last_i;
          end
        end
      end
    end

    // One match byte: read the source, write the copy at the output position.
    if (emit) begin
      issue_o.byte_v     = 1'b1;
      issue_o.byte_match = 1'b1;
      issue_o.rd_addr    = produced_q[HistAw-1:0] - match_distance_d;
      issue_o.wr_addr    = produced_q[HistAw-1:0];
      produced_d         = produced_q + 1'b1;
      match_left_d       = emit_len - 1'b1;
      input_ended_d      = ended_eff;
      issue_o.busy       = (match_left_d != '0);
      if (match_left_d == '0) begin
        phase_d = PH_TOKEN;
        if (ended_eff) begin
          end_req = 1'b1;
        end
      end else begin
        phase_d = PH_COPY;
      end
    end

    if (end_req && produced_d != expected_i) begin
      fail      = 1'b1;
      fail_code = ERR_SIZE_MISMATCH;
    end

    if (fail || end_req) begin
      issue_o.fin_v    = 1'b1;
      issue_o.fin_kind = fail ? KIND_ERROR : KIND_DONE;
      issue_o.fin_err  = fail ? fail_code : ERR_NONE;
      phase_d          = PH_TOKEN;
      match_nibble_d   = '0;
      length_accum_d   = '0;
      literals_left_d  = '0;
      match_distance_d = '0;
      match_left_d     = '0;
      produced_d       = '0;
      input_ended_d    = 1'b0;
    end
  end

  assign rd_en_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_TOKEN;
      match_nibble_q   <= '0;
      length_accum_q   <= '0;
      literals_left_q  <= '0;
      match_distance_q <= '0;
      match_left_q     <= '0;
      produced_q       <= '0;
      input_ended_q    <= 1'b0;
    end else begin
      phase_q          <= phase_d;
      match_nibble_q   <= match_nibble_d;
      length_accum_q   <= length_accum_d;
      literals_left_q  <= literals_left_d;
      match_distance_q <= match_distance_d;
      match_left_q     <= match_left_d;
      produced_q       <= produced_d;
      input_ended_q    <= input_ended_d;
    end
  end

endmodule

// ===== rtl/lz4bd_resolve.sv =====
module lz4bd_resolve import lz4bd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  issue_t     issue_i,
  input  logic [7:0] rd_data_i,
  output logic       wr_en_o,
  output haddr_t     wr_addr_o,
  output logic [7:0] wr_data_o,
  output logic [1:0] push_n_o,
  output result_t    push0_o,
  output result_t    push1_o
);

  logic       valid_q;
  issue_t     issue_q;
  logic       fwd_q;
  logic [7:0] fwd_byte_q;
  logic [7:0] byte_val;
  result_t    byte_res, fin_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      valid_q <= fire_i;
      if (fire_i) begin
        // The byte being written now is not yet visible to this edge's read.
        fwd_q <= issue_i.byte_match && wr_en_o && (wr_addr_o == issue_i.rd_addr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      issue_q    <= issue_i;
      fwd_byte_q <= wr_data_o;
    end
  end

  always_comb begin
    if (issue_q.byte_match) begin
      byte_val = fwd_q ? fwd_byte_q : rd_data_i;
    end else begin
      byte_val = issue_q.lit_byte;
    end

    byte_res.kind       = issue_q.byte_match ? KIND_MATCH : KIND_LITERAL;
    byte_res.out_byte   = byte_val;
    byte_res.error_code = ERR_NONE;
    byte_res.busy_res   = issue_q.busy;
    byte_res.run_last   = !issue_q.fin_v;

    fin_res.kind        = issue_q.fin_kind;
    fin_res.out_byte    = '0;
    fin_res.error_code  = issue_q.fin_err;
    fin_res.busy_res    = 1'b0;
    fin_res.run_last    = 1'b1;
  end

  assign wr_en_o   = valid_q && issue_q.byte_v;
  assign wr_addr_o = issue_q.wr_addr;
  assign wr_data_o = byte_val;
  assign push_n_o  = valid_q ? (2'(issue_q.byte_v) + 2'(issue_q.fin_v)) : 2'd0;
  assign push0_o   = issue_q.byte_v ? byte_res : fin_res;
  assign push1_o   = fin_res;

endmodule

// ===== rtl/lz4bd_out_fifo.sv =====
module lz4bd_out_fifo import lz4bd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_n_i,
  input  result_t           push0_i,
  input  result_t           push1_i,
  input  logic              pop_i,
  output logic              valid_o,
  output result_t           head_o,
  output logic [FifoAw:0]   count_o
);

  result_t             mem_q [FifoDepth];
  logic [FifoAw-1:0]   wptr_q, rptr_q;
  logic [FifoAw:0]     count_q;

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wptr_q + 1'b1] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + FifoAw'(push_n_i);
      rptr_q  <= rptr_q + FifoAw'(pop_i);
      count_q <= count_q + (FifoAw+1)'(push_n_i) - (FifoAw+1)'(pop_i);
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign count_o = count_q;

endmodule

// ===== rtl/lz4_block_decompressor_unit.sv =====
// LZ4 block decoder. Compressed bytes (op 0) and drain ticks (op 1) enter on
// in_i; decoded literal bytes, match bytes and one final status (done or
// error) per block leave on out_o. Both channels are
// valid/ready. The expected output size is to be written through cfg_we_i and
// cfg_wdata_i between blocks; the block itself does not enforce this.
// An accepted request updates the parse state in the same cycle and starts
// the history read; the next cycle resolves the match byte, writes it to
// the 64 KiB history RAM and pushes its results into the result queue,
// whose head drives out_o. While in_i.ready is high a request is accepted
// every cycle; the single history port pair (one read, one write per cycle)
// sets that rate. A match of length L needs its completing byte plus L-1 ticks.
// A request can give two results, so a run of those drains at one per cycle
// while out_o.ready is high. Results wait in a four-entry queue; in_i.ready
// drops only when the queue could not take two more results, so a stalled
// receiver backs up into the sender without losing anything.
// Reset clears the parser and counters and sets the expected size to zero.
// The history RAM is not cleared: offsets are checked against the bytes
// written in the current block, so stale contents are never read.
module lz4_block_decompressor_unit import lz4bd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  size_t             cfg_wdata_i,
  lz4bd_in_if.sink          in_i,
  lz4bd_out_if.source       out_o
);

  size_t            expected_q;
  logic             in_fire;
  issue_t           issue;
  logic             rd_en;
  logic [7:0]       rd_data;
  logic             wr_en;
  haddr_t           wr_addr;
  logic [7:0]       wr_data;
  logic [1:0]       push_n;
  result_t          push0, push1;
  result_t          head;
  logic             head_valid;
  logic [FifoAw:0]  fifo_count;
  logic             pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= '0;
    end else if (cfg_we_i) begin
      expected_q <= cfg_wdata_i;
    end
  end

  // Room for the worst case of the next request once pending results land.
  assign in_i.ready = ((fifo_count + (FifoAw+1)'(push_n)) <= (FifoAw+1)'(FifoDepth - MaxResults));
  assign in_fire    = in_i.valid && in_i.ready;

  lz4bd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .op_i        (in_i.op),
    .data_byte_i (in_i.data_byte),
    .is_last_i   (in_i.is_last),
    .expected_i  (expected_q),
    .issue_o     (issue),
    .rd_en_o     (rd_en)
  );

  lz4bd_history u_history (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (issue.rd_addr),
    .rd_data_o (rd_data)
  );

  lz4bd_resolve u_resolve (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (in_fire),
    .issue_i   (issue),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .push_n_o  (push_n),
    .push0_o   (push0),
    .push1_o   (push1)
  );

  assign pop = head_valid && out_o.ready;

  lz4bd_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (push0),
    .push1_i  (push1),
    .pop_i    (pop),
    .valid_o  (head_valid),
    .head_o   (head),
    .count_o  (fifo_count)
  );

  assign out_o.valid      = head_valid;
  assign out_o.kind       = head.kind;
  assign out_o.out_byte   = head.out_byte;
  assign out_o.error_code = head.error_code;
  assign out_o.busy_res   = head.busy_res;
  assign out_o.run_last   = head.run_last;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_count + (FifoAw+1)'(push_n)) <= (FifoAw+1)'(FifoDepth))
    else $error("result queue overflow");

  a_byte_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && issue.byte_v |=> wr_en)
    else $error("decoded byte not written to history");

  a_final_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && issue.fin_v && issue.byte_v |-> !issue.busy)
    else $error("final status while a copy is still pending");
`endif

endmodule

// ===== tb/tb_lz4_block_decompressor_unit.sv =====
`timescale 1ns / 1ps

module tb_lz4_block_decompressor_unit;
  import lz4bd_pkg::*;

  localparam int unsigned CycleLimit   = 1_500_000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomItems  = 1150;
  localparam logic [24:0] SatCap       = 25'h100_0000;
  localparam logic        OP_BYTE      = 1'b0;
  localparam logic        OP_TICK      = 1'b1;

  typedef enum logic [2:0] {
    ST_TOKEN,
    ST_LIT_EXT,
    ST_LIT_DATA,
    ST_OFS_LO,
    ST_OFS_HI,
    ST_MAT_EXT,
    ST_DRAIN
  } seq_state_e;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       last;
  } req_t;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cfg_we_i;
  size_t cfg_wdata_i;

  lz4bd_in_if  in_if ();
  lz4bd_out_if out_if ();

  lz4_block_decompressor_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Decoder state as the block should hold it.
  size_t       size_cfg;
  seq_state_e  seq;
  logic [3:0]  mat_nib;
  logic [24:0] len_sum;
  size_t       lits_due;
  logic [15:0] distance;
  logic [24:0] copy_due;
  size_t       out_count;
  logic        tail_seen;
  logic [7:0]  window [HistDepth];

  result_t     decoded_q [$];
  req_t        plan_q [$];

  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned counted_items = 0;
  int unsigned hold_ask      = 0;
  bit          quiet         = 1'b0;
  bit          offering      = 1'b0;

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [24:0] sat_sum(logic [24:0] a, logic [24:0] b);
    logic [25:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, SatCap}) ? SatCap : s[24:0];
  endfunction

  function automatic logic [24:0] room();
    return (size_cfg > out_count) ? {1'b0, size_cfg - out_count} : '0;
  endfunction

  function automatic void expect_res(kind_e k, logic [7:0] b, err_e e, logic busy);
    result_t r;
    r.kind       = k;
    r.out_byte   = b;
    r.error_code = e;
    r.busy_res   = busy;
    r.run_last   = 1'b0;
    decoded_q.push_back(r);
  endfunction

  function automatic void restart_block();
    seq       = ST_TOKEN;
    mat_nib   = '0;
    len_sum   = '0;
    lits_due  = '0;
    distance  = '0;
    copy_due  = '0;
    out_count = '0;
    tail_seen = 1'b0;
  endfunction

  function automatic void abort(err_e e);
    expect_res(KIND_ERROR, 8'h00, e, 1'b0);
    restart_block();
  endfunction

  function automatic void close_block();
    if (out_count == size_cfg) begin
      expect_res(KIND_DONE, 8'h00, ERR_NONE, 1'b0);
      restart_block();
    end else begin
      abort(ERR_SIZE_MISMATCH);
    end
  endfunction

  function automatic void copy_one();
    haddr_t     src;
    logic [7:0] b;
    src = out_count[15:0] - distance;
    b = window[src];
    window[out_count[15:0]] = b;
    out_count = out_count + 1'b1;
    copy_due = copy_due - 1'b1;
    expect_res(KIND_MATCH, b, ERR_NONE, copy_due != 0);
    if (copy_due == 0) begin
      seq = ST_TOKEN;
      if (tail_seen) close_block();
    end else begin
      seq = ST_DRAIN;
    end
  endfunction

  function automatic void begin_copy(logic [24:0] len, logic last);
    if (len > room()) begin
      abort(ERR_MATCH_OVERRUN);
    end else begin
      copy_due  = len;
      tail_seen = last;
      copy_one();
    end
  endfunction

  function automatic void begin_literals(logic [24:0] len, logic last);
    if (len == 0) begin
      if (last) close_block();
      else seq = ST_OFS_LO;
    end else if (last) begin
      abort(ERR_TRUNCATED);
    end else if (len > room()) begin
      abort(ERR_LIT_OVERRUN);
    end else begin
      lits_due = len[23:0];
      seq = ST_LIT_DATA;
    end
  endfunction

  function automatic void decode_request(req_t r);
    int unsigned n0;
    result_t     tail;
    n0 = decoded_q.size();
    if (r.op == OP_TICK) begin
      if (seq == ST_DRAIN && copy_due != 0) copy_one();
    end else begin
      case (seq)
        ST_TOKEN: begin
          mat_nib = r.data[3:0];
          if (r.data[7:4] == ExtNibble) begin
            len_sum = 25'(ExtNibble);
            if (r.last) abort(ERR_TRUNCATED);
            else seq = ST_LIT_EXT;
          end else begin
            begin_literals(25'(r.data[7:4]), r.last);
          end
        end
        ST_LIT_EXT: begin
          len_sum = sat_sum(len_sum, 25'(r.data));
          if (r.data == ExtByte) begin
            if (r.last) abort(ERR_TRUNCATED);
          end else begin
            begin_literals(len_sum, r.last);
          end
        end
        ST_LIT_DATA: begin
          window[out_count[15:0]] = r.data;
          out_count = out_count + 1'b1;
          lits_due = lits_due - 1'b1;
          expect_res(KIND_LITERAL, r.data, ERR_NONE, 1'b0);
          if (lits_due == 0) begin
            if (r.last) close_block();
            else seq = ST_OFS_LO;
          end else if (r.last) begin
            abort(ERR_TRUNCATED);
          end
        end
        ST_OFS_LO: begin
          distance = {8'h00, r.data};
          if (r.last) abort(ERR_TRUNCATED);
          else seq = ST_OFS_HI;
        end
        ST_OFS_HI: begin
          distance[15:8] = r.data;
          if (distance == 0 || distance > out_count) begin
            abort(ERR_BAD_OFFSET);
          end else if (mat_nib == ExtNibble) begin
            len_sum = 25'(ExtNibble);
            if (r.last) abort(ERR_TRUNCATED);
            else seq = ST_MAT_EXT;
          end else begin
            begin_copy(25'(mat_nib) + 25'(MinMatch), r.last);
          end
        end
        ST_MAT_EXT: begin
          len_sum = sat_sum(len_sum, 25'(r.data));
          if (r.data == ExtByte) begin
            if (r.last) abort(ERR_TRUNCATED);
          end else begin
            begin_copy(sat_sum(len_sum, 25'(MinMatch)), r.last);
          end
        end
        default: begin
          abort(ERR_BUSY);
        end
      endcase
    end
    if (decoded_q.size() > n0) begin
      tail = decoded_q.pop_back();
      tail.run_last = 1'b1;
      decoded_q.push_back(tail);
    end
  endfunction

  function automatic void plan(logic op, logic [7:0] b, logic last);
    req_t r;
    r.op   = op;
    r.data = b;
    r.last = last;
    plan_q.push_back(r);
  endfunction

  function automatic void plan_ext(int unsigned extra);
    while (extra >= 255) begin
      plan(OP_BYTE, ExtByte, 1'b0);
      extra -= 255;
    end
    plan(OP_BYTE, 8'(extra), 1'b0);
  endfunction

  function automatic void mark_tail();
    req_t r;
    r = plan_q.pop_back();
    r.last = 1'b1;
    plan_q.push_back(r);
  endfunction

  function automatic int unsigned pick_len(int unsigned lo, int unsigned hi);
    int unsigned r;
    int unsigned v;
    r = $urandom_range(0, 19);
    if (r < 14) v = lo + $urandom_range(0, 8);
    else if (r < 19) v = lo + $urandom_range(9, 40);
    else v = lo + $urandom_range(255, 300);
    return (v > hi) ? hi : v;
  endfunction

  // Builds one well-formed block that decodes to exactly total bytes.
  function automatic void plan_block(int unsigned total);
    int unsigned done_bytes;
    int unsigned left;
    int unsigned lit_n;
    int unsigned mat_n;
    int unsigned ofs;
    int unsigned i;
    logic        match_ends;
    plan_q.delete();
    done_bytes = 0;
    while (1) begin
      left = total - done_bytes;
      if (left < MinMatch || (done_bytes == 0 && left < 5) || $urandom_range(0, 7) == 0) begin
        lit_n = left;
        plan(OP_BYTE, {(lit_n >= 15) ? 4'hF : 4'(lit_n), 4'($urandom_range(0, 15))}, 1'b0);
        if (lit_n >= 15) plan_ext(lit_n - 15);
        for (i = 0; i < lit_n; i++) plan(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
        mark_tail();
        break;
      end
      lit_n = pick_len((done_bytes == 0) ? 1 : 0, left - MinMatch);
      mat_n = pick_len(MinMatch, left - lit_n);
      if ($urandom_range(0, 1) == 0)
        ofs = $urandom_range(1, (done_bytes + lit_n < 8) ? done_bytes + lit_n : 8);
      else
        ofs = $urandom_range(1, done_bytes + lit_n);
      match_ends = (mat_n == left - lit_n) && ($urandom_range(0, 1) == 0);
      plan(OP_BYTE, {(lit_n >= 15) ? 4'hF : 4'(lit_n),
                     (mat_n - MinMatch >= 15) ? 4'hF : 4'(mat_n - MinMatch)}, 1'b0);
      if (lit_n >= 15) plan_ext(lit_n - 15);
      for (i = 0; i < lit_n; i++) plan(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
      plan(OP_BYTE, 8'(ofs), 1'b0);
      plan(OP_BYTE, 8'(ofs >> 8), 1'b0);
      if (mat_n - MinMatch >= 15) plan_ext(mat_n - MinMatch - 15);
      if (match_ends) mark_tail();
      // The byte and last fields of a tick carry no meaning, so they are random.
      for (i = 1; i < mat_n; i++)
        plan(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 19) == 0)
        plan(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      done_bytes += lit_n + mat_n;
      if (match_ends) break;
    end
  endfunction

  function automatic void break_plan();
    int unsigned idx;
    req_t        r;
    idx = $urandom_range(0, plan_q.size() - 1);
    case ($urandom_range(0, 3))
      0: begin
        while (plan_q.size() > idx + 1) void'(plan_q.pop_back());
        r = plan_q.pop_back();
        r.op   = OP_BYTE;
        r.last = 1'b1;
        plan_q.push_back(r);
      end
      1: begin
        r = plan_q[idx];
        r.data = 8'($urandom_range(0, 255));
        plan_q[idx] = r;
      end
      2: begin
        r = plan_q[idx];
        r.op   = OP_BYTE;
        r.data = 8'($urandom_range(0, 255));
        plan_q[idx] = r;
      end
      default: begin
        repeat ($urandom_range(1, 5)) begin
          r.op   = 1'($urandom_range(0, 1));
          r.data = 8'($urandom_range(0, 255));
          r.last = 1'($urandom_range(0, 1));
          plan_q.push_front(r);
        end
      end
    endcase
  endfunction

  task automatic send_req(req_t r);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      if (offering) begin
        in_if.valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    if (!offering) begin
      in_if.valid <= 1'b1;
      offering = 1'b1;
    end
    in_if.op        <= r.op;
    in_if.data_byte <= r.data;
    in_if.is_last   <= r.last;
    do @(posedge clk_i); while (!in_if.ready);
    if (r.op == OP_BYTE || seq == ST_DRAIN) counted_items++;
    decode_request(r);
  endtask

  task automatic send_plan(int pause_at);
    int   i;
    req_t r;
    i = 0;
    while (plan_q.size() != 0) begin
      if (i == pause_at) wait_results();
      r = plan_q.pop_front();
      send_req(r);
      i++;
    end
  endtask

  task automatic wait_results();
    if (offering) begin
      in_if.valid <= 1'b0;
      offering = 1'b0;
      @(posedge clk_i);
    end
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  // A trailing tick can leave the block working with nothing expected.
  task automatic wait_idle();
    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_size(size_t v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    size_cfg = v;
    cfg_we_i <= 1'b0;
  endtask

  // Brings the decoder back to the start of a block after a broken sequence.
  task automatic resync();
    req_t r;
    while (seq != ST_TOKEN || out_count != 0) begin
      r.op   = (seq == ST_DRAIN) ? OP_TICK : OP_BYTE;
      r.data = 8'($urandom_range(0, 255));
      r.last = 1'b1;
      send_req(r);
    end
  endtask

  task automatic test_config_extremes();
    set_size('0);
    plan_q.delete();
    plan(OP_BYTE, 8'h00, 1'b1);
    send_plan(-1);
    set_size('1);
    plan(OP_BYTE, 8'h00, 1'b1);
    send_plan(-1);
  endtask

  task automatic test_match_copy();
    set_size(24'd5);
    plan_q.delete();
    plan(OP_BYTE, 8'h10, 1'b0);
    plan(OP_BYTE, 8'hA5, 1'b0);
    plan(OP_BYTE, 8'h01, 1'b0);
    plan(OP_BYTE, 8'h00, 1'b1);
    repeat (3) plan(OP_TICK, 8'h00, 1'b0);
    // Nothing is pending any more, so this tick must be ignored.
    plan(OP_TICK, 8'hFF, 1'b1);
    send_plan(-1);
  endtask

  task automatic test_error_paths();
    set_size(24'd4);
    plan_q.delete();
    plan(OP_BYTE, 8'hF0, 1'b1);
    plan(OP_BYTE, 8'hF0, 1'b0);
    plan(OP_BYTE, 8'hFF, 1'b1);
    plan(OP_BYTE, 8'h50, 1'b0);
    plan(OP_BYTE, 8'h20, 1'b0);
    plan(OP_BYTE, 8'h33, 1'b1);
    plan(OP_BYTE, 8'h00, 1'b0);
    plan(OP_BYTE, 8'h00, 1'b0);
    plan(OP_BYTE, 8'h00, 1'b0);
    plan(OP_BYTE, 8'h10, 1'b0);
    plan(OP_BYTE, 8'h44, 1'b0);
    plan(OP_BYTE, 8'h00, 1'b0);
    plan(OP_BYTE, 8'h80, 1'b0);
    plan(OP_BYTE, 8'h11, 1'b0);
    plan(OP_BYTE, 8'h55, 1'b0);
    plan(OP_BYTE, 8'h01, 1'b0);
    plan(OP_BYTE, 8'h00, 1'b0);
    plan(OP_BYTE, 8'h10, 1'b0);
    plan(OP_BYTE, 8'h66, 1'b0);
    plan(OP_BYTE, 8'h01, 1'b0);
    plan(OP_BYTE, 8'h00, 1'b0);
    plan(OP_BYTE, 8'h77, 1'b0);
    plan(OP_BYTE, 8'h10, 1'b0);
    plan(OP_BYTE, 8'h44, 1'b1);
    send_plan(-1);
  endtask

  task automatic test_backpressure();
    int unsigned half;
    quiet = 1'b1;
    set_size(24'd160);
    plan_block(160);
    hold_ask = 250;
    send_plan(-1);
    resync();
    plan_block(160);
    half = plan_q.size() / 2;
    send_plan(half);
    resync();
    quiet = 1'b0;
  endtask

  task automatic test_random_blocks();
    size_t       target;
    int unsigned total;
    int unsigned pick;
    counted_items = 0;
    while (counted_items < RandomItems) begin
      quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick == 0) target = '0;
      else if (pick == 1) target = '1;
      else if (pick < 5) target = 24'($urandom_range(1, 9));
      else if (pick == 5) target = 24'($urandom_range(300, 600));
      else target = 24'($urandom_range(10, 150));
      set_size(target);
      repeat ($urandom_range(1, 4)) begin
        total = (target > 600) ? $urandom_range(10, 100) : target;
        pick = $urandom_range(0, 19);
        if (pick == 0) total = total + 1;
        else if (pick == 1 && total > 0) total = total - 1;
        plan_block(total);
        if ($urandom_range(0, 6) == 0) break_plan();
        send_plan(($urandom_range(0, 19) == 0) ? $urandom_range(0, plan_q.size() - 1) : -1);
        resync();
      end
    end
    quiet = 1'b0;
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : check_results
    result_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, kind %0d", out_if.kind));
      end else begin
        e = decoded_q.pop_front();
        check_field("kind", 8'(out_if.kind), 8'(e.kind));
        check_field("out_byte", out_if.out_byte, e.out_byte);
        check_field("error_code", 8'(out_if.error_code), 8'(e.error_code));
        check_field("busy_res", 8'(out_if.busy_res), 8'(e.busy_res));
        check_field("run_last", 8'(out_if.run_last), 8'(e.run_last));
      end
    end
  end

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (hold_ask > 0) begin
        stall_left = hold_ask - 1;
        hold_ask = 0;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = pick_gap() - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_lz4_block_decompressor_unit: done, errors");
      $finish;
    end
  end

  initial begin
    in_if.valid     <= 1'b0;
    in_if.op        <= OP_BYTE;
    in_if.data_byte <= 8'h00;
    in_if.is_last   <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    size_cfg = '0;
    restart_block();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_config_extremes();
    test_match_copy();
    test_error_paths();
    test_backpressure();
    test_random_blocks();
    wait_idle();
    if (mismatches == 0) begin
      $display("tb_lz4_block_decompressor_unit: done, clean");
    end else begin
      $display("tb_lz4_block_decompressor_unit: done, errors");
    end
    $finish;
  end

endmodule
